FILE: rtl/core/dmlc_pkg.sv
// ----------------------------------------------------------------------------
// Door motor and lock controller package
// Shared types and constants for the controller state, the configuration
// registers and one input request.
// ----------------------------------------------------------------------------
`default_nettype none

package dmlc_pkg;

    localparam int unsigned DEBOUNCE_W = 4;
    localparam int unsigned TIMEOUT_W  = 6;
    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned CFG_IDX_W  = 2;

    // Request kinds carried in s_tuser.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIMEOUT   = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_LIMIT_RST = 4'd3;
    localparam logic [TIMEOUT_W-1:0]  CLOSE_TIMEOUT_RST  = 6'd40;
    localparam logic [TIMEOUT_W-1:0]  OPEN_TIMEOUT_RST   = 6'd15;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX     = 4'd15;
    localparam logic [TIMEOUT_W-1:0]  OPEN_START_COUNT = 6'd3;
    localparam logic [TIMEOUT_W-1:0]  CLOSE_START_COUNT = 6'd1;

    // Switch level that reads as a closed door.
    localparam logic SWITCH_CLOSED = 1'b0;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_limit;
        logic [TIMEOUT_W-1:0]  close_timeout;
        logic [TIMEOUT_W-1:0]  open_timeout;
    } cfg_t;

    typedef struct packed {
        logic operation;
        logic switch_level;
        logic motor_request;
        logic lock_request;
    } item_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] closed_run_count;
        logic                  open_status;
        logic [TIMEOUT_W-1:0]  move_count;
        logic                  closing_flag;
        logic                  lock_pending;
        logic                  pending_lock_value;
        logic                  drive_close;
        logic                  drive_open;
        logic                  lock_line;
    } state_t;

    localparam state_t STATE_RST = '{
        closed_run_count:   '0,
        open_status:        1'b0,
        move_count:         '0,
        closing_flag:       1'b0,
        lock_pending:       1'b0,
        pending_lock_value: 1'b0,
        drive_close:        1'b0,
        drive_open:         1'b0,
        lock_line:          1'b0
    };

endpackage

`default_nettype wire

FILE: rtl/core/dmlc_step.sv
// ----------------------------------------------------------------------------
// Door controller step logic
// Computes the next controller state from the current state, the
// configuration and one tick or command request.
// ----------------------------------------------------------------------------
`default_nettype none

module dmlc_step (
    input  wire dmlc_pkg::state_t state_cur,
    input  wire dmlc_pkg::cfg_t   cfg,
    input  wire dmlc_pkg::item_t  item,
    output dmlc_pkg::state_t      state_nxt
);

    dmlc_pkg::state_t                 s;
    logic [dmlc_pkg::TIMEOUT_W:0]     count_inc;

    always_comb begin
        s         = state_cur;
        count_inc = '0;
        if (item.operation == dmlc_pkg::OP_TICK) begin
            if (item.switch_level == dmlc_pkg::SWITCH_CLOSED) begin
                if (s.closed_run_count > cfg.debounce_limit) begin
                    s.open_status = 1'b0;
                end else begin
                    if (s.closed_run_count < dmlc_pkg::DEBOUNCE_MAX) begin
                        s.closed_run_count = s.closed_run_count + 1'b1;
                    end
                    s.open_status = 1'b1;
                end
            end else begin
                s.open_status      = 1'b1;
                s.closed_run_count = '0;
            end

            if (s.closing_flag) begin
                // A closing run ends when the door reads closed.
                if (!s.open_status) begin
                    s.move_count   = '0;
                    s.closing_flag = 1'b0;
                    s.drive_close  = 1'b0;
                    s.drive_open   = 1'b0;
                    if (s.lock_pending) begin
                        s.lock_line    = s.pending_lock_value;
                        s.lock_pending = 1'b0;
                    end
                end
                count_inc = {1'b0, s.move_count} + 1'b1;
                if (count_inc > {1'b0, cfg.close_timeout}) begin
                    s.move_count   = '0;
                    s.closing_flag = 1'b0;
                    s.drive_close  = 1'b0;
                    s.drive_open   = 1'b0;
                end else begin
                    s.move_count = count_inc[dmlc_pkg::TIMEOUT_W-1:0];
                end
            end else if (s.move_count != '0) begin
                count_inc = {1'b0, s.move_count} + 1'b1;
                if (count_inc > {1'b0, cfg.open_timeout}) begin
                    s.move_count  = '0;
                    s.drive_close = 1'b0;
                    s.drive_open  = 1'b0;
                end else begin
                    s.move_count = count_inc[dmlc_pkg::TIMEOUT_W-1:0];
                end
            end
        end else begin
            if (item.motor_request && !s.open_status) begin
                s.lock_line   = item.lock_request;
                s.drive_close = 1'b0;
                s.drive_open  = 1'b1;
                s.move_count  = dmlc_pkg::OPEN_START_COUNT;
            end else if (!item.motor_request && s.open_status) begin
                s.drive_close        = 1'b1;
                s.drive_open         = 1'b0;
                s.move_count         = dmlc_pkg::CLOSE_START_COUNT;
                s.closing_flag       = 1'b1;
                s.lock_pending       = 1'b1;
                s.pending_lock_value = item.lock_request;
            end else begin
                s.lock_line = item.lock_request;
            end
        end
        state_nxt = s;
    end

endmodule

`default_nettype wire

FILE: rtl/core/door_motor_lock_controller.sv
// ----------------------------------------------------------------------------
// Door motor and lock controller
// A request is held in the item register, then its result in the output
// register on m_tvalid. Throughput: one request per cycle unless m_tready
// stalls the output. Reset (aresetn low, synchronous) stops the motor, clears
// the lock line, marks the door closed and loads the default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module door_motor_lock_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_we,
    input  wire logic [dmlc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dmlc_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // switch_level, motor_request,
                                                             // lock_request, zero fill
    input  wire logic                              s_tuser,  // operation

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata   // drive_close, drive_open,
                                                             // lock_out, door_is_open, zero fill
);

    dmlc_pkg::cfg_t   cfg_reg;
    dmlc_pkg::item_t  item_reg;
    logic             item_valid_reg;
    dmlc_pkg::state_t state_reg;
    dmlc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic [3:0]       out_bits_reg;
    logic             advance;

    // The step stage moves forward whenever the result register is empty or m_tready takes it.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_limit <= dmlc_pkg::DEBOUNCE_LIMIT_RST;
            cfg_reg.close_timeout  <= dmlc_pkg::CLOSE_TIMEOUT_RST;
            cfg_reg.open_timeout   <= dmlc_pkg::OPEN_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                dmlc_pkg::REG_DEBOUNCE_LIMIT: begin
                    cfg_reg.debounce_limit <= cfg_data[dmlc_pkg::DEBOUNCE_W-1:0];
                end
                dmlc_pkg::REG_CLOSE_TIMEOUT: begin
                    cfg_reg.close_timeout <= cfg_data[dmlc_pkg::TIMEOUT_W-1:0];
                end
                dmlc_pkg::REG_OPEN_TIMEOUT: begin
                    cfg_reg.open_timeout <= cfg_data[dmlc_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.operation     <= s_tuser;
            item_reg.switch_level  <= s_tdata[0];
            item_reg.motor_request <= s_tdata[1];
            item_reg.lock_request  <= s_tdata[2];
        end
    end

    dmlc_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .item      (item_reg),
        .state_nxt (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dmlc_pkg::STATE_RST;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= item_valid_reg;
            if (item_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid_reg) begin
            out_bits_reg <= {state_next.open_status, state_next.lock_line,
                             state_next.drive_open, state_next.drive_close};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_bits_reg};

endmodule

`default_nettype wire
